// ===== hw/rtl/dsrs_pkg.sv =====
// Shared types, constants and the CRC-32 word step for the dual slot record selector.
// No dependencies; every other file of the block imports this package.
package dsrs_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned POS_W  = 5;
   localparam int unsigned CSR_W  = 2;

   localparam logic [WORD_W-1:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] HALF_RANGE = 32'h8000_0000;

   // Register indexes on the configuration port
   localparam logic [CSR_W-1:0] CSR_MAGIC     = 2'd0;
   localparam logic [CSR_W-1:0] CSR_VERSION   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_MARKER    = 2'd2;
   localparam logic [CSR_W-1:0] CSR_UNMEASURE = 2'd3;

   // Word positions inside one record
   localparam logic [POS_W-1:0] POS_MAGIC      = 5'd0;
   localparam logic [POS_W-1:0] POS_VERSION    = 5'd1;
   localparam logic [POS_W-1:0] POS_SEQUENCE   = 5'd2;
   localparam logic [POS_W-1:0] POS_STAGE      = 5'd3;
   localparam logic [POS_W-1:0] POS_STAGE_INV  = 5'd4;
   localparam logic [POS_W-1:0] POS_STACK_RAW  = 5'd10;
   localparam logic [POS_W-1:0] POS_STACK_BYTE = 5'd11;
   localparam logic [POS_W-1:0] POS_SAMPLE     = 5'd17;
   localparam logic [POS_W-1:0] POS_MARKER     = 5'd18;
   localparam logic [POS_W-1:0] POS_CHECKSUM   = 5'd19;
   localparam logic [POS_W-1:0] BODY_WORDS     = 5'd18;

   typedef struct packed {
      logic [WORD_W-1:0] magic;
      logic [WORD_W-1:0] version;
      logic [WORD_W-1:0] marker;
      logic [WORD_W-1:0] unmeasured;
   } cfg_type;

   // Outcome of a record pair, offered on the last word of slot 1
   typedef struct packed {
      logic              last;
      logic              slot0_ok;
      logic              slot1_ok;
      logic [WORD_W-1:0] seq0;
      logic [WORD_W-1:0] seq1;
   } pair_type;

   // Reflected CRC-32 over one word, low byte first; collapses to an XOR network
   function automatic logic [WORD_W-1:0] crc32_word(input logic [WORD_W-1:0] crc,
                                                    input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] c;
      c = crc ^ w;
      for (int i = 0; i < WORD_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/dsrs_channels.sv =====
// Valid/ready channel interfaces for record words in and pair results out.
// Depends on dsrs_pkg for the word width.
interface dsrs_req_if;
   import dsrs_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              restart;

   modport source (output valid, output word, output restart, input ready);
   modport sink   (input valid, input word, input restart, output ready);
endinterface

interface dsrs_rsp_if;
   import dsrs_pkg::*;
   logic              valid;
   logic              ready;
   logic              have_valid;
   logic              selected_slot;
   logic              slot0_valid;
   logic              slot1_valid;
   logic [WORD_W-1:0] newest_sequence;

   modport source (output valid, output have_valid, output selected_slot,
                   output slot0_valid, output slot1_valid, output newest_sequence,
                   input ready);
   modport sink   (input valid, input have_valid, input selected_slot,
                   input slot0_valid, input slot1_valid, input newest_sequence,
                   output ready);
endinterface

// ===== hw/rtl/dsrs_record_check.sv =====
// Per-word record checking: CRC, field checks, word position and slot tracking.
// Depends on dsrs_pkg for constants, cfg_type, pair_type and crc32_word.
module dsrs_record_check
   import dsrs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [WORD_W-1:0] word,
   input  logic              restart,
   input  cfg_type           cfg,
   output pair_type          pair
);

   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              slot_ff, slot_in;
   logic              ok_ff, ok_in;
   logic [WORD_W-1:0] stage_ff, stage_in;
   logic              stack_ff, stack_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic              first_ok_ff, first_ok_in;
   logic [WORD_W-1:0] first_seq_ff, first_seq_in;

   // Effective state for this word: restart starts a fresh pair
   logic [WORD_W-1:0] crc_c, stage_c, seq_c, first_seq_c;
   logic [POS_W-1:0]  pos_c;
   logic              slot_c, ok_c, stack_c, first_ok_c;
   // Updated values after this word
   logic [WORD_W-1:0] crc_n, stage_n, seq_n;
   logic              ok_n, stack_n, last;

   always_comb begin
      crc_c       = restart ? ALL_ONES : crc_ff;
      pos_c       = restart ? '0 : pos_ff;
      slot_c      = restart ? 1'b0 : slot_ff;
      ok_c        = restart ? 1'b1 : ok_ff;
      stage_c     = restart ? '0 : stage_ff;
      stack_c     = restart ? 1'b1 : stack_ff;
      seq_c       = restart ? '0 : seq_ff;
      first_ok_c  = restart ? 1'b0 : first_ok_ff;
      first_seq_c = restart ? '0 : first_seq_ff;
   end

   // Check the word against its position
   always_comb begin
      crc_n   = (pos_c < BODY_WORDS) ? crc32_word(crc_c, word) : crc_c;
      ok_n    = ok_c;
      stage_n = stage_c;
      stack_n = stack_c;
      seq_n   = seq_c;
      case (pos_c)
         POS_MAGIC: begin
            if (word != cfg.magic) ok_n = 1'b0;
         end
         POS_VERSION: begin
            if (word != cfg.version) ok_n = 1'b0;
         end
         POS_SEQUENCE: begin
            seq_n = word;
            if (word == '0) ok_n = 1'b0;
         end
         POS_STAGE: begin
            stage_n = word;
         end
         POS_STAGE_INV: begin
            if (word != ~stage_c) ok_n = 1'b0;
         end
         POS_STACK_RAW, POS_STACK_BYTE: begin
            if (word != cfg.unmeasured) stack_n = 1'b0;
         end
         POS_SAMPLE: begin
            if (word > 32'd1 || (word == '0 && !stack_c)) ok_n = 1'b0;
         end
         POS_MARKER: begin
            if (word != cfg.marker) ok_n = 1'b0;
         end
         POS_CHECKSUM: begin
            if (word != (crc_c ^ ALL_ONES)) ok_n = 1'b0;
         end
         default: ;
      endcase
      last = (pos_c == POS_CHECKSUM);
   end

   // Next state: advance within a record, or close the record
   always_comb begin
      crc_in       = crc_n;
      pos_in       = pos_c + 5'd1;
      slot_in      = slot_c;
      ok_in        = ok_n;
      stage_in     = stage_n;
      stack_in     = stack_n;
      seq_in       = seq_n;
      first_ok_in  = first_ok_c;
      first_seq_in = first_seq_c;
      if (last) begin
         crc_in   = ALL_ONES;
         pos_in   = '0;
         ok_in    = 1'b1;
         stage_in = '0;
         stack_in = 1'b1;
         seq_in   = '0;
         if (!slot_c) begin
            slot_in      = 1'b1;
            first_ok_in  = ok_n;
            first_seq_in = seq_n;
         end else begin
            slot_in      = 1'b0;
            first_ok_in  = 1'b0;
            first_seq_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= ALL_ONES;
         pos_ff       <= '0;
         slot_ff      <= 1'b0;
         ok_ff        <= 1'b1;
         stage_ff     <= '0;
         stack_ff     <= 1'b1;
         seq_ff       <= '0;
         first_ok_ff  <= 1'b0;
         first_seq_ff <= '0;
      end else if (step) begin
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         ok_ff        <= ok_in;
         stage_ff     <= stage_in;
         stack_ff     <= stack_in;
         seq_ff       <= seq_in;
         first_ok_ff  <= first_ok_in;
         first_seq_ff <= first_seq_in;
      end
   end

   // Offer the pair outcome when this word closes slot 1
   always_comb begin
      pair.last     = last && slot_c;
      pair.slot0_ok = first_ok_c;
      pair.slot1_ok = ok_n;
      pair.seq0     = first_seq_c;
      pair.seq1     = seq_n;
   end

endmodule

// ===== hw/rtl/dsrs_select.sv =====
// Newest-slot selection by serial-number comparison and the result register.
// Depends on dsrs_pkg for pair_type and the half-range constant.
module dsrs_select
   import dsrs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pair_type          pair,
   input  logic              out_ready,
   output logic              out_valid,
   output logic              have_valid,
   output logic              selected_slot,
   output logic              slot0_valid,
   output logic              slot1_valid,
   output logic [WORD_W-1:0] newest_sequence
);

   logic              valid_ff;
   logic              any_ff, sel_ff, v0_ff, v1_ff;
   logic [WORD_W-1:0] seq_ff;

   logic              newer, any_in, sel_in;
   logic [WORD_W-1:0] diff, seq_in;

   // Slot 1 wins only when strictly ahead by less than half the range, or when it alone is valid
   always_comb begin
      diff   = pair.seq1 - pair.seq0;
      newer  = (pair.seq1 != '0) && (pair.seq0 != '0) && (diff != '0) && (diff < HALF_RANGE);
      any_in = pair.slot0_ok || pair.slot1_ok;
      if (pair.slot0_ok && pair.slot1_ok) sel_in = newer;
      else                                sel_in = pair.slot1_ok;
      if (!any_in)     seq_in = '0;
      else if (sel_in) seq_in = pair.seq1;
      else             seq_in = pair.seq0;
   end

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         any_ff <= any_in;
         sel_ff <= sel_in;
         v0_ff  <= pair.slot0_ok;
         v1_ff  <= pair.slot1_ok;
         seq_ff <= seq_in;
      end
   end

   assign out_valid       = valid_ff;
   assign have_valid      = any_ff;
   assign selected_slot   = sel_ff;
   assign slot0_valid     = v0_ff;
   assign slot1_valid     = v1_ff;
   assign newest_sequence = seq_ff;

endmodule

// ===== hw/rtl/dual_slot_record_selector.sv =====
// Dual slot record selector top level: configuration registers, input register and handshake.
// Depends on dsrs_pkg, dsrs_channels, dsrs_record_check and dsrs_select.
//
// The block takes one record word per clock unless the input side stalls: slot 0's twenty words,
// then slot 1's, with restart marking word 0 of slot 0. A word is captured in the input register,
// then checked and folded into the CRC from that register. On the last word of slot 1 the pair
// result is written to the result register at the end of that cycle and presented from there.
// The sustained rate is one word per cycle while no stall holds it, set by the combinational CRC
// word step. The input side stalls only when a pair result is due while the previous result
// still waits in the result register. Configuration registers are written through the csr port
// by the user only while no words are in flight; the block itself does not enforce this.
module dual_slot_record_selector
   import dsrs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   dsrs_req_if.sink          req_chan,
   dsrs_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [WORD_W-1:0] csr_write_data
);

   cfg_type           cfg_ff;
   logic              in_valid_ff;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_restart_ff;

   pair_type          pair;
   logic              stall, advance, step, load;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAGIC:     cfg_ff.magic      <= csr_write_data;
            CSR_VERSION:   cfg_ff.version    <= csr_write_data;
            CSR_MARKER:    cfg_ff.marker     <= csr_write_data;
            CSR_UNMEASURE: cfg_ff.unmeasured <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stall only when a result is due and the result register is still occupied
   assign stall   = in_valid_ff && pair.last && rsp_chan.valid && !rsp_chan.ready;
   assign advance = !stall;
   assign step    = in_valid_ff && !stall;
   assign load    = step && pair.last;
   assign req_chan.ready = advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         in_word_ff    <= req_chan.word;
         in_restart_ff <= req_chan.restart;
      end
   end

   dsrs_record_check u_check (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .word    (in_word_ff),
      .restart (in_restart_ff),
      .cfg     (cfg_ff),
      .pair    (pair)
   );

   dsrs_select u_select (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .pair            (pair),
      .out_ready       (rsp_chan.ready),
      .out_valid       (rsp_chan.valid),
      .have_valid      (rsp_chan.have_valid),
      .selected_slot   (rsp_chan.selected_slot),
      .slot0_valid     (rsp_chan.slot0_valid),
      .slot1_valid     (rsp_chan.slot1_valid),
      .newest_sequence (rsp_chan.newest_sequence)
   );

   // A loaded result is presented in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid)
      else $error("result not presented after load");

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !load)
      else $error("result register overwritten");

   // Selection is consistent with the per-slot flags
   a_select_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.have_valid == (rsp_chan.slot0_valid || rsp_chan.slot1_valid))
                          && (!rsp_chan.selected_slot || rsp_chan.slot1_valid)
                          && (rsp_chan.have_valid || rsp_chan.newest_sequence == '0)))
      else $error("inconsistent selection result");

endmodule

// ===== tb/sv/dual_slot_record_selector_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dual_slot_record_selector: streams record pairs, predicts each pair result.
// Depends on dsrs_pkg, the dsrs_channels interfaces and the dual_slot_record_selector top level.
module dual_slot_record_selector_tb
   import dsrs_pkg::*;
();

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [3:0] {
      FLT_NONE, FLT_MAGIC, FLT_VERSION, FLT_MARKER, FLT_ZERO_SEQ,
      FLT_STAGE_INV, FLT_CHECKSUM, FLT_SAMPLE_RANGE, FLT_STACK
   } fault_type;

   typedef struct packed {
      logic              have_valid;
      logic              selected_slot;
      logic              slot0_valid;
      logic              slot1_valid;
      logic [WORD_W-1:0] newest_sequence;
   } pair_result_type;

   typedef struct packed {
      logic [WORD_W-1:0] seq0;
      fault_type         flt0;
      logic [WORD_W-1:0] seq1;
      fault_type         flt1;
      logic              restart;
      logic              typed;
      pair_result_type   want;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset;
   logic              csr_write_enable;
   logic [CSR_W-1:0]  csr_index;
   logic [WORD_W-1:0] csr_write_data;

   dsrs_req_if req_chan ();
   dsrs_rsp_if rsp_chan ();

   dual_slot_record_selector DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Directed pairs, register values all zero; most outcomes typed in
   pair_row_type plan [12] = '{
      '{32'd5,          FLT_NONE,         32'd6,          FLT_NONE,     1'b1, 1'b1,
        '{1'b1, 1'b1, 1'b1, 1'b1, 32'd6}},
      '{32'd7,          FLT_NONE,         32'd7,          FLT_NONE,     1'b0, 1'b1,
        '{1'b1, 1'b0, 1'b1, 1'b1, 32'd7}},
      '{32'd1,          FLT_NONE,         32'h8000_0001,  FLT_NONE,     1'b1, 1'b1,
        '{1'b1, 1'b0, 1'b1, 1'b1, 32'd1}},
      '{32'hFFFF_FFFF,  FLT_NONE,         32'd1,          FLT_NONE,     1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b1, 1'b1, 32'd1}},
      '{32'd10,         FLT_CHECKSUM,     32'd3,          FLT_NONE,     1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b1, 32'd3}},
      '{32'd0,          FLT_ZERO_SEQ,     32'd8,          FLT_MARKER,   1'b1, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
      '{32'd9,          FLT_MAGIC,        32'd9,          FLT_NONE,     1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b1, 32'd9}},
      '{32'h12,         FLT_NONE,         32'h40,         FLT_SAMPLE_RANGE, 1'b0, 1'b1,
        '{1'b1, 1'b0, 1'b1, 1'b0, 32'h12}},
      '{32'd3,          FLT_STAGE_INV,    32'd4,          FLT_VERSION,  1'b1, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
      '{32'd4,          FLT_STACK,        32'h7FFF_FFFF,  FLT_NONE,     1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF}},
      '{32'h8000_0000,  FLT_NONE,         32'hFFFF_FFFF,  FLT_NONE,     1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF}},
      '{32'h8000_0000,  FLT_NONE,         32'h0,          FLT_NONE,     1'b1, 1'b0,
        '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}}
   };

   // Register mirror
   logic [WORD_W-1:0] cfg_magic, cfg_version, cfg_marker, cfg_unmeasured;

   // Selector state mirror
   logic [WORD_W-1:0] crc_acc;
   logic [POS_W-1:0]  pos;
   logic              in_slot1;
   logic              rec_good;
   logic [WORD_W-1:0] stage_word;
   logic              stack_sentinel;
   logic [WORD_W-1:0] seq_word;
   logic              slot0_good;
   logic [WORD_W-1:0] slot0_seq;

   pair_result_type pending_outcomes [$];
   pair_row_type    typed_outcomes [$];
   logic [WORD_W-1:0] pair_words [40];

   int failures = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   bit aligned = 1'b0;
   int gap_odds = 0;

   // Reflected CRC-32, one bit per step, low bit first
   function automatic logic [WORD_W-1:0] crc32_step(input logic [WORD_W-1:0] acc,
                                                   input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] c;
      c = acc ^ w;
      repeat (WORD_W) c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      return c;
   endfunction

   function automatic void open_record();
      crc_acc        = ALL_ONES;
      pos            = '0;
      rec_good       = 1'b1;
      stage_word     = '0;
      stack_sentinel = 1'b1;
      seq_word       = '0;
   endfunction

   function automatic void open_pair();
      open_record();
      in_slot1   = 1'b0;
      slot0_good = 1'b0;
      slot0_seq  = '0;
   endfunction

   // Fold one accepted word into the record checks; queue the pair outcome on its last word
   task automatic fold_word(input logic [WORD_W-1:0] w, input logic rs);
      pair_result_type r;
      pair_row_type    row;
      logic            pick1;
      if (rs)
         open_pair();
      if (pos < BODY_WORDS)
         crc_acc = crc32_step(crc_acc, w);
      case (pos)
         POS_MAGIC:    if (w != cfg_magic) rec_good = 1'b0;
         POS_VERSION:  if (w != cfg_version) rec_good = 1'b0;
         POS_SEQUENCE: begin
            seq_word = w;
            if (w == '0) rec_good = 1'b0;
         end
         POS_STAGE:    stage_word = w;
         POS_STAGE_INV: if (w != ~stage_word) rec_good = 1'b0;
         POS_STACK_RAW, POS_STACK_BYTE: if (w != cfg_unmeasured) stack_sentinel = 1'b0;
         POS_SAMPLE:   if (w > 1 || (w == '0 && !stack_sentinel)) rec_good = 1'b0;
         POS_MARKER:   if (w != cfg_marker) rec_good = 1'b0;
         POS_CHECKSUM: if (w != ~crc_acc) rec_good = 1'b0;
         default: ;
      endcase
      if (pos != POS_CHECKSUM) begin
         pos = pos + 1'b1;
      end else if (!in_slot1) begin
         slot0_good = rec_good;
         slot0_seq  = seq_word;
         open_record();
         in_slot1 = 1'b1;
      end else begin
         // serial-number compare: slot 1 wins only when ahead by less than half the range
         pick1 = 1'b0;
         if (slot0_good && rec_good)
            pick1 = seq_word != '0 && slot0_seq != '0 && seq_word != slot0_seq &&
                    (seq_word - slot0_seq) < HALF_RANGE;
         else if (rec_good)
            pick1 = 1'b1;
         r.have_valid      = slot0_good | rec_good;
         r.selected_slot   = pick1;
         r.slot0_valid     = slot0_good;
         r.slot1_valid     = rec_good;
         r.newest_sequence = !r.have_valid ? '0 : (pick1 ? seq_word : slot0_seq);
         if (typed_outcomes.size() != 0) begin
            row = typed_outcomes.pop_front();
            if (row.typed)
               r = row.want;
         end
         pending_outcomes.push_back(r);
         open_pair();
      end
   endtask

   task automatic check_outcome(input pair_result_type got);
      pair_result_type want;
      if (pending_outcomes.size() == 0) begin
         $error("pair result with no pair pending");
         failures++;
      end else begin
         want = pending_outcomes.pop_front();
         if (got.have_valid !== want.have_valid) begin
            $error("have_valid: expected %0d, got %0d", want.have_valid, got.have_valid);
            failures++;
         end
         if (got.selected_slot !== want.selected_slot) begin
            $error("selected_slot: expected %0d, got %0d", want.selected_slot,
                   got.selected_slot);
            failures++;
         end
         if (got.slot0_valid !== want.slot0_valid) begin
            $error("slot0_valid: expected %0d, got %0d", want.slot0_valid, got.slot0_valid);
            failures++;
         end
         if (got.slot1_valid !== want.slot1_valid) begin
            $error("slot1_valid: expected %0d, got %0d", want.slot1_valid, got.slot1_valid);
            failures++;
         end
         if (got.newest_sequence !== want.newest_sequence) begin
            $error("newest_sequence: expected %08h, got %08h", want.newest_sequence,
                   got.newest_sequence);
            failures++;
         end
      end
   endtask

   // Watch both channels; all drivers use nonblocking updates, so these are pre-edge values
   always @(posedge clock) begin
      if (req_chan.valid && req_chan.ready)
         fold_word(req_chan.word, req_chan.restart);
      if (rsp_chan.valid && rsp_chan.ready)
         check_outcome('{rsp_chan.have_valid, rsp_chan.selected_slot, rsp_chan.slot0_valid,
                         rsp_chan.slot1_valid, rsp_chan.newest_sequence});
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: stall in bursts, none once the run goes quiet
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Hold one word until its transfer, then maybe idle a burst
   task automatic send_word(input logic [WORD_W-1:0] w, input logic rs);
      req_chan.valid   <= 1'b1;
      req_chan.word    <= w;
      req_chan.restart <= rs;
      do @(posedge clock); while (!req_chan.ready);
      if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Build a 20-word record at base under the current registers, with the given fault, if any, applied
   task automatic fill_record(input int base, input logic [WORD_W-1:0] seq,
                              input fault_type flt);
      logic [WORD_W-1:0] crc, stage, nz;
      logic              sample;
      nz = $urandom;
      if (nz == '0) nz = 32'h1;
      stage  = $urandom;
      sample = 1'($urandom_range(0, 1));
      for (int i = 0; i < 20; i++)
         pair_words[base + i] = $urandom;
      pair_words[base + POS_MAGIC]     = cfg_magic;
      pair_words[base + POS_VERSION]   = cfg_version;
      pair_words[base + POS_SEQUENCE]  = seq;
      pair_words[base + POS_STAGE]     = stage;
      pair_words[base + POS_STAGE_INV] = ~stage;
      pair_words[base + POS_SAMPLE]    = {31'd0, sample};
      pair_words[base + POS_MARKER]    = cfg_marker;
      if (!sample || flt == FLT_STACK) begin
         pair_words[base + POS_STACK_RAW]  = cfg_unmeasured;
         pair_words[base + POS_STACK_BYTE] = cfg_unmeasured;
      end
      case (flt)
         FLT_MAGIC:     pair_words[base + POS_MAGIC] ^= nz;
         FLT_VERSION:   pair_words[base + POS_VERSION] ^= nz;
         FLT_MARKER:    pair_words[base + POS_MARKER] ^= nz;
         FLT_ZERO_SEQ:  pair_words[base + POS_SEQUENCE] = '0;
         FLT_STAGE_INV: pair_words[base + POS_STAGE_INV] ^= nz;
         FLT_SAMPLE_RANGE:
            pair_words[base + POS_SAMPLE] = $urandom_range(0, 1) ? ALL_ONES : ($urandom | 32'h2);
         FLT_STACK: begin
            // unmeasured sample with a stack word that lost its sentinel
            pair_words[base + POS_SAMPLE] = '0;
            if ($urandom_range(0, 1))
               pair_words[base + POS_STACK_RAW] ^= nz;
            else
               pair_words[base + POS_STACK_BYTE] ^= nz;
         end
         default: ;
      endcase
      crc = ALL_ONES;
      for (int i = 0; i < BODY_WORDS; i++)
         crc = crc32_step(crc, pair_words[base + i]);
      pair_words[base + POS_CHECKSUM] = ~crc;
      if (flt == FLT_CHECKSUM)
         pair_words[base + POS_CHECKSUM] ^= nz;
   endtask

   task automatic send_pair(input logic [WORD_W-1:0] seq0, input fault_type flt0,
                            input logic [WORD_W-1:0] seq1, input fault_type flt1,
                            input logic rs, input int count);
      fill_record(0, seq0, flt0);
      fill_record(20, seq1, flt1);
      for (int i = 0; i < count; i++)
         send_word(pair_words[i], i == 0 ? rs : 1'b0);
   endtask

   // Stop sending and wait until every pair result is in and the pipeline is empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [WORD_W-1:0] magic, version, marker, unmeasured);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAGIC;
      csr_write_data   <= magic;
      @(posedge clock);
      csr_index        <= CSR_VERSION;
      csr_write_data   <= version;
      @(posedge clock);
      csr_index        <= CSR_MARKER;
      csr_write_data   <= marker;
      @(posedge clock);
      csr_index        <= CSR_UNMEASURE;
      csr_write_data   <= unmeasured;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_magic      = magic;
      cfg_version    = version;
      cfg_marker     = marker;
      cfg_unmeasured = unmeasured;
   endtask

   function automatic logic [WORD_W-1:0] pick_seq();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(1, 8);
         1:       return ALL_ONES - $urandom_range(0, 3);
         2:       return 32'h7FFF_FFFF + $urandom_range(0, 2);
         default: return $urandom;
      endcase
   endfunction

   // Step from slot 0 to slot 1 around the serial-number boundaries
   function automatic logic [WORD_W-1:0] pick_delta();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'd1;
         2:       return 32'h7FFF_FFFF;
         3:       return HALF_RANGE;
         4:       return 32'h8000_0001;
         5:       return ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   function automatic fault_type pick_fault();
      if ($urandom_range(0, 2) != 0)
         return FLT_NONE;
      return fault_type'($urandom_range(1, int'(FLT_STACK)));
   endfunction

   // Mostly well-formed pairs; the rest truncated pairs and loose words
   task automatic run_phase(input int pairs, input bit hold_mid, input bit quiet_tail);
      logic [WORD_W-1:0] s0;
      for (int p = 0; p < pairs; p++) begin
         if (quiet_tail && p >= pairs / 2)
            quiet = 1'b1;
         if (hold_mid && p == pairs / 2)
            settle();
         gap_odds = $urandom_range(0, 2) == 0 ? 0 : 6;
         s0 = pick_seq();
         if ($urandom_range(0, 4) != 0) begin
            send_pair(s0, pick_fault(), s0 + pick_delta(), pick_fault(),
                      aligned ? 1'($urandom_range(0, 1)) : 1'b1, 40);
            aligned = 1'b1;
         end else if ($urandom_range(0, 1)) begin
            send_pair(s0, pick_fault(), s0 + pick_delta(), pick_fault(), 1'b1,
                      $urandom_range(1, 39));
            aligned = 1'b0;
         end else begin
            repeat ($urandom_range(1, 45))
               send_word($urandom, $urandom_range(0, 7) == 0);
            aligned = 1'b0;
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.word    <= '0;
      req_chan.restart <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_MAGIC;
      csr_write_data   <= '0;
      cfg_magic      = '0;
      cfg_version    = '0;
      cfg_marker     = '0;
      cfg_unmeasured = '0;
      open_pair();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs at the reset register values
      gap_odds = 4;
      foreach (plan[r]) begin
         typed_outcomes.push_back(plan[r]);
         send_pair(plan[r].seq0, plan[r].flt0, plan[r].seq1, plan[r].flt1, plan[r].restart, 40);
      end
      aligned = 1'b1;
      settle();

      program_regs(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      run_phase(5, 1'b0, 1'b0);
      settle();
      program_regs($urandom, $urandom, $urandom, $urandom);
      run_phase(6, 1'b1, 1'b0);
      settle();
      program_regs('0, '0, $urandom, '0);
      run_phase(5, 1'b0, 1'b0);
      settle();
      program_regs($urandom, ALL_ONES, '0, $urandom);
      run_phase(6, 1'b0, 1'b1);
      settle();

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
